### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the keypad scanner checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("keypad scanner assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("keypad scanner reset assertion failed");

`endif

### hdl/kmsd_pkg.sv
// ----------------------------------------------------------------------------
// kmsd_pkg
// Types and constants of the 3x4 keypad scanner with per-key debounce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmsd_pkg;

   localparam int KEY_COUNT = 12;
   localparam int COL_COUNT = 3;
   localparam int ROW_COUNT = 4;
   localparam int DEB_BITS  = 16;
   localparam int KEY_IDX_BITS = $clog2(KEY_COUNT);

   typedef logic [KEY_COUNT-1:0]    key_vec_type;
   typedef logic [ROW_COUNT-1:0]    rows_type;
   typedef logic [DEB_BITS-1:0]     deb_type;
   typedef logic [KEY_IDX_BITS-1:0] key_idx_type;

   localparam deb_type DEBOUNCE_RESET = 16'd35;

   // Key number for each column and row.
   localparam key_idx_type KEY_MAP [COL_COUNT][ROW_COUNT] = '{
      '{4'd1, 4'd4, 4'd7, 4'd10},
      '{4'd2, 4'd5, 4'd8, 4'd0},
      '{4'd3, 4'd6, 4'd9, 4'd11}
   };

endpackage

### hdl/keypad_matrix_scan_debounce.sv
// ----------------------------------------------------------------------------
// keypad_matrix_scan_debounce
// Decodes one 3x4 keypad scan per transfer and debounces all twelve keys.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the req_ channel is one complete keypad scan: the millisecond
// timestamp of the scan and, for each of the three columns, the active-low row
// levels seen while that column was driven low. Within a column only the
// lowest-numbered low row counts. Every scan produces exactly one transfer on
// the rsp_ channel with a pressed mask and a released mask, one bit per key.
// The csr_ channel writes the debounce time in milliseconds; it is always
// ready and must only be written while no scan is in flight.
// A scan passes two registers on its way to rsp_valid: the scan register,
// then the decode and debounce compare into the result register. Throughput
// is one scan per cycle while the receiver keeps up, set by the twelve
// parallel subtract-and-compare paths between those two registers.
// When the receiver stalls, the result register holds its value and the scan
// register still fills, so one more scan is taken before req_ready drops.
// Synchronous reset empties both registers, clears every key's raw sample,
// debounced level and change time to zero, and sets the debounce time to 35.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_matrix_scan_debounce #(
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // Scan request channel.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [31:0]            req_now_ms,
   input  kmsd_pkg::rows_type     req_col0_rows,
   input  kmsd_pkg::rows_type     req_col1_rows,
   input  kmsd_pkg::rows_type     req_col2_rows,
   // Result channel.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output kmsd_pkg::key_vec_type  rsp_pressed_mask,
   output kmsd_pkg::key_vec_type  rsp_released_mask,
   // Debounce time register write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  kmsd_pkg::deb_type      csr_debounce_ms
);

   import kmsd_pkg::*;

   typedef logic [TIME_BITS-1:0] time_type;

   // Scan register.
   logic        scan_valid_ff, scan_valid_in;
   time_type    scan_now_ff;
   rows_type    scan_rows_ff [COL_COUNT];

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   key_vec_type pressed_ff, pressed_in;
   key_vec_type released_ff, released_in;

   // Debounce time register.
   deb_type     debounce_ff;

   // Per-key state.
   key_vec_type level_ff, level_in;
   key_vec_type prev_raw_ff;
   time_type    change_time_ff [KEY_COUNT];
   time_type    change_time_in [KEY_COUNT];

   // Working signals.
   logic        req_take;
   logic        scan_adv;
   key_vec_type raw_keys;
   time_type    elapsed [KEY_COUNT];
   logic        found;

   // The scan register moves on whenever the result register is empty or is
   // being emptied in this cycle, so a new scan can enter every cycle.
   assign scan_adv  = scan_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !scan_valid_ff || scan_adv;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign scan_valid_in = req_take || (scan_valid_ff && !scan_adv);
   assign rsp_valid_in  = scan_adv || (rsp_valid_ff && !rsp_ready);

   // Priority decode: the first low row of each column selects its key, the
   // other keys of that column read as released.
   always_comb begin
      raw_keys = '0;
      for (int c = 0; c < COL_COUNT; c++) begin
         found = 1'b0;
         for (int r = 0; r < ROW_COUNT; r++) begin
            if (!found && !scan_rows_ff[c][r]) begin
               raw_keys[KEY_MAP[c][r]] = 1'b1;
               found = 1'b1;
            end
         end
      end
   end

   // Debounce of all keys in parallel. A raw change restarts the key's timer,
   // which then reads zero elapsed time and so never passes the compare.
   always_comb begin
      level_in    = level_ff;
      pressed_in  = '0;
      released_in = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         change_time_in[k] = (raw_keys[k] != prev_raw_ff[k]) ? scan_now_ff
                                                              : change_time_ff[k];
         elapsed[k] = scan_now_ff - change_time_in[k];
         if ((elapsed[k] > TIME_BITS'(debounce_ff)) && (raw_keys[k] != level_ff[k])) begin
            level_in[k] = raw_keys[k];
            if (raw_keys[k]) begin
               pressed_in[k] = 1'b1;
            end else begin
               released_in[k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         debounce_ff   <= DEBOUNCE_RESET;
         level_ff      <= '0;
         prev_raw_ff   <= '0;
         for (int k = 0; k < KEY_COUNT; k++) begin
            change_time_ff[k] <= '0;
         end
      end else begin
         scan_valid_ff <= scan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            debounce_ff <= csr_debounce_ms;
         end
         if (scan_adv) begin
            level_ff    <= level_in;
            prev_raw_ff <= raw_keys;
            for (int k = 0; k < KEY_COUNT; k++) begin
               change_time_ff[k] <= change_time_in[k];
            end
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         scan_now_ff     <= TIME_BITS'(req_now_ms);
         scan_rows_ff[0] <= req_col0_rows;
         scan_rows_ff[1] <= req_col1_rows;
         scan_rows_ff[2] <= req_col2_rows;
      end
      if (scan_adv) begin
         pressed_ff  <= pressed_in;
         released_ff <= released_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pressed_mask  = pressed_ff;
   assign rsp_released_mask = released_ff;

endmodule

### hdl/kmsd_checker.sv
// ----------------------------------------------------------------------------
// kmsd_checker
// Port-level assertions for the keypad scanner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kmsd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input kmsd_pkg::key_vec_type rsp_pressed_mask,
   input kmsd_pkg::key_vec_type rsp_released_mask
);

   import kmsd_pkg::*;

   // A key cannot debounce to pressed and released in the same scan.
   `ASSERT_CLK(a_no_overlap, clock, reset,
               rsp_valid |-> ((rsp_pressed_mask & rsp_released_mask) == '0))

   // A result that is not taken stays in place.
   `ASSERT_CLK(a_rsp_hold, clock, reset,
               (rsp_valid && !rsp_ready) |=>
               (rsp_valid && $stable(rsp_pressed_mask) && $stable(rsp_released_mask)))

   // When the result side drains or is empty, the request side is open.
   `ASSERT_CLK(a_req_open, clock, reset, (rsp_ready || !rsp_valid) |-> req_ready)

   // Reset empties the result register.
   `ASSERT_CLK_NR(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

endmodule

bind keypad_matrix_scan_debounce kmsd_checker u_kmsd_checker (.*);

### dv/tb_keypad_matrix_scan_debounce.sv
// ----------------------------------------------------------------------------
// tb_keypad_matrix_scan_debounce
// Self-checking bench for the 3x4 keypad scanner with per-key debounce. Scans
// are pushed through the request channel under random flow control, and a
// scoreboard works out the expected press and release masks of every scan and
// compares them in order with the result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keypad_matrix_scan_debounce;

   import kmsd_pkg::*;

   // Press and release masks that one scan is expected to report.
   typedef struct packed {
      key_vec_type pressed;
      key_vec_type released;
   } key_events_type;

   // Tracks the debounce state of all twelve keys and holds, oldest first, the
   // masks still owed by the block for the scans it has taken.
   class key_event_board;
      deb_type        debounce_ms;
      key_vec_type    level;
      key_vec_type    last_raw;
      logic [31:0]    change_ms [KEY_COUNT];
      key_events_type owed_events [$];
      int unsigned    failures;

      function new();
         debounce_ms = DEBOUNCE_RESET;
         level       = '0;
         last_raw    = '0;
         foreach (change_ms[k]) change_ms[k] = '0;
         failures    = 0;
      endfunction

      function int pending();
         return owed_events.size();
      endfunction

      function void note_scan(logic [31:0] now_ms, rows_type c0, rows_type c1, rows_type c2);
         rows_type       cols [COL_COUNT];
         key_vec_type    raw;
         key_events_type ev;
         logic [31:0]    elapsed;
         cols = '{c0, c1, c2};
         raw  = '0;
         ev   = '0;
         // The first low row of a column wins; the rest of that column reads released.
         for (int c = 0; c < COL_COUNT; c++) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
               if (!cols[c][r]) begin
                  raw[KEY_MAP[c][r]] = 1'b1;
                  break;
               end
            end
         end
         for (int k = 0; k < KEY_COUNT; k++) begin
            if (raw[k] != last_raw[k]) change_ms[k] = now_ms;
            elapsed = now_ms - change_ms[k];
            if (elapsed > {16'd0, debounce_ms} && raw[k] != level[k]) begin
               level[k] = raw[k];
               if (raw[k]) ev.pressed[k] = 1'b1;
               else ev.released[k] = 1'b1;
            end
         end
         last_raw = raw;
         owed_events.push_back(ev);
      endfunction

      function void check_result(key_vec_type pressed, key_vec_type released);
         key_events_type want;
         if (owed_events.size() == 0) begin
            $error("result transfer with no scan outstanding: pressed %03h released %03h",
                   pressed, released);
            failures++;
            return;
         end
         want = owed_events.pop_front();
         if (pressed !== want.pressed) begin
            $error("pressed_mask mismatch: expected %03h, actual %03h", want.pressed, pressed);
            failures++;
         end
         if (released !== want.released) begin
            $error("released_mask mismatch: expected %03h, actual %03h",
                   want.released, released);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_now_ms;
   rows_type    req_col0_rows;
   rows_type    req_col1_rows;
   rows_type    req_col2_rows;
   logic        rsp_valid;
   logic        rsp_ready;
   key_vec_type rsp_pressed_mask;
   key_vec_type rsp_released_mask;
   logic        csr_valid;
   logic        csr_ready;
   deb_type     csr_debounce_ms;

   key_event_board board;

   // Percentages of cycles in which each side idles, changed between phases.
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   // Long receiver hold-off: the stimulus raises the request, the receiver
   // process counts the stretch down on its own.
   bit          hold_request;
   int unsigned hold_left;

   // Running scan timestamp of the random part.
   logic [31:0] scan_ms;

   keypad_matrix_scan_debounce dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_now_ms        (req_now_ms),
      .req_col0_rows     (req_col0_rows),
      .req_col1_rows     (req_col1_rows),
      .req_col2_rows     (req_col2_rows),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pressed_mask  (rsp_pressed_mask),
      .rsp_released_mask (rsp_released_mask),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_debounce_ms   (csr_debounce_ms)
   );

   always #1 clock = ~clock;

   // Receiver: ready changes on the falling edge, either held low for a
   // requested stretch or dropped at random according to the idle rate.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = 60;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Every result transfer is checked against the oldest owed masks.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_pressed_mask, rsp_released_mask);
      end
   end

   // Offers one scan, after a random number of idle cycles, and records it in
   // the scoreboard at the edge of its transfer. Entered and left on a falling
   // edge, so valid stays high without a glitch between back-to-back scans.
   task automatic send_scan(input logic [31:0] now_ms, input rows_type c0, input rows_type c1,
                            input rows_type c2);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_now_ms    <= now_ms;
      req_col0_rows <= c0;
      req_col1_rows <= c1;
      req_col2_rows <= c2;
      do @(posedge clock); while (!req_ready);
      board.note_scan(now_ms, c0, c1, c2);
      @(negedge clock);
   endtask

   // Holds the sender back until every owed result has been received.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Writes the debounce time; only called while no scan is in flight.
   task automatic write_debounce(input deb_type value);
      csr_valid       <= 1'b1;
      csr_debounce_ms <= value;
      do @(posedge clock); while (!csr_ready);
      board.debounce_ms = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random scans that look like real key use: each column holds a pattern
   // for a while, contacts bounce now and then, and time mostly advances in
   // steps of up to a third of the debounce time (8 ms when it is short), with exact boundary steps, near-repeats and
   // the odd jump anywhere in the 32-bit range (wraps and backward steps).
   task automatic run_scans(input int count);
      rows_type    held [COL_COUNT];
      rows_type    c [COL_COUNT];
      int unsigned span;
      int unsigned pick;
      span = (board.debounce_ms < 16'd16) ? 8 : int'(board.debounce_ms) / 3;
      foreach (held[col]) held[col] = 4'hF;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) scan_ms = scan_ms + $urandom_range(0, span);
         else if (pick < 80) scan_ms = scan_ms + board.debounce_ms + $urandom_range(0, 1);
         else if (pick < 95) scan_ms = scan_ms + $urandom_range(0, 2);
         else scan_ms = $urandom;
         if ($urandom_range(0, 99) < 15) begin
            foreach (held[col]) begin
               case ($urandom_range(0, 3))
                  0: held[col] = 4'hF;
                  1: held[col] = ~(rows_type'(1) << $urandom_range(0, 3));
                  default: held[col] = rows_type'($urandom_range(0, 15));
               endcase
            end
         end
         c = held;
         // A single scan of contact bounce on one column.
         if ($urandom_range(0, 99) < 10) begin
            c[$urandom_range(0, COL_COUNT - 1)] = rows_type'($urandom_range(0, 15));
         end
         send_scan(scan_ms, c[0], c[1], c[2]);
      end
   endtask

   initial begin
      board           = new();
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_now_ms      = '0;
      req_col0_rows   = 4'hF;
      req_col1_rows   = 4'hF;
      req_col2_rows   = 4'hF;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_debounce_ms = '0;
      send_idle_pct   = 11;
      recv_idle_pct   = 55;
      hold_request    = 1'b0;
      hold_left       = 0;
      scan_ms         = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed scans at the reset debounce time of 35 ms.
      send_scan(32'd0, 4'hF, 4'hF, 4'hF);     // nothing pressed
      send_scan(32'd10, 4'hE, 4'hF, 4'hF);    // key 1 goes down
      send_scan(32'd45, 4'hE, 4'hF, 4'hF);    // exactly the debounce time: no event
      send_scan(32'd46, 4'hE, 4'hF, 4'hF);    // one past it: key 1 pressed
      send_scan(32'd50, 4'hF, 4'h0, 4'hF);    // all rows low: only key 2 counts
      send_scan(32'd86, 4'hF, 4'h0, 4'hF);
      send_scan(32'd100, 4'h0, 4'h0, 4'h0);   // keys 1, 2 and 3
      send_scan(32'd200, 4'h0, 4'h0, 4'h0);
      send_scan(32'd210, 4'hD, 4'hB, 4'h7);   // second, third and fourth rows
      send_scan(32'd300, 4'hD, 4'hB, 4'h7);
      send_scan(32'd310, 4'h7, 4'h7, 4'hB);   // keys 10, 0 and 9
      send_scan(32'd400, 4'h7, 4'h7, 4'hB);
      send_scan(32'd410, 4'hB, 4'hD, 4'hD);   // keys 7, 5 and 6
      send_scan(32'd500, 4'hB, 4'hD, 4'hD);
      // The timestamp wraps between a release and its debounce.
      send_scan(32'hFFFF_FFF0, 4'hF, 4'hF, 4'hF);
      send_scan(32'h0000_0020, 4'hF, 4'hF, 4'hF);
      send_scan(32'hFFFF_FFFF, 4'h0, 4'h0, 4'h0);
      send_scan(32'h0000_0023, 4'h0, 4'h0, 4'h0);
      // A backward step looks like a huge elapsed time.
      send_scan(32'd5, 4'hF, 4'hF, 4'hF);
      send_scan(32'd3, 4'hF, 4'hF, 4'hF);
      // Contact bounce restarts the debounce time.
      send_scan(32'd100, 4'hE, 4'hF, 4'hF);
      send_scan(32'd110, 4'hF, 4'hF, 4'hF);
      send_scan(32'd120, 4'hE, 4'hF, 4'hF);
      send_scan(32'd155, 4'hE, 4'hF, 4'hF);
      send_scan(32'd156, 4'hE, 4'hF, 4'hF);

      // Zero debounce: any change held for at least 1 ms counts.
      wait_results_drained();
      write_debounce(16'd0);
      run_scans(350);

      // A typical debounce time, with a long receiver stall in the middle so
      // that the block fills up and stops taking scans.
      wait_results_drained();
      write_debounce(deb_type'($urandom_range(5, 40)));
      run_scans(200);
      hold_request = 1'b1;
      run_scans(250);

      // Sender busy, receiver mostly ready.
      send_idle_pct = 55;
      recv_idle_pct = 11;
      wait_results_drained();
      write_debounce(16'hFFFF);
      run_scans(150);
      wait_results_drained();
      write_debounce(16'd1);
      run_scans(150);
      wait_results_drained();
      run_scans(150);

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_results_drained();
      write_debounce(deb_type'($urandom_range(0, 65535)));
      run_scans(300);
      wait_results_drained();
      write_debounce(deb_type'($urandom_range(0, 15)));
      hold_request = 1'b1;
      run_scans(100);

      wait_results_drained();
      repeat (4) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
